// ===== rtl/core/sensor_frame_checksum_deframer_defines.svh =====
// Assertion macros shared by the sensor frame deframer RTL.
`ifndef SENSOR_FRAME_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SENSOR_FRAME_CHECKSUM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define SFCD_ASSERT_IMPLIES(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SFCD_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sfcd_pkg.sv =====
// Types and constants for the sensor frame deframer.
package sfcd_pkg;

    localparam logic [7:0] HEADER_BYTE  = 8'hAA;
    localparam logic [4:0] FIRST_DATA   = 5'd1;
    localparam logic [4:0] CHECK_INDEX  = 5'd23;
    localparam logic [4:0] GAS_FIRST    = 5'd18;
    localparam int         FIELD_COUNT  = 5;
    localparam logic [2:0] GAS_SLOT     = 3'd4;
    localparam int         RESULT_BITS  = 1 + 32 * FIELD_COUNT;
    localparam int         TDATA_BITS   = ((RESULT_BITS + 7) / 8) * 8;

    // Declared MSB first so frame_ok lands in bit 0 when packed.
    typedef struct packed {
        logic [31:0] gas_raw;
        logic [31:0] voltage_three_raw;
        logic [31:0] voltage_two_raw;
        logic [31:0] voltage_one_raw;
        logic [31:0] temperature_raw;
        logic        frame_ok;
    } result_t;

    typedef struct packed {
        logic in_frame;
        logic is_check;
    } parse_status_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] slot;
        logic [1:0] pos;
    } place_t;

    // Map a frame byte index to its field slot and byte lane.
    function automatic place_t byte_place(logic [4:0] idx);
        place_t     pl;
        logic [4:0] off;
        pl  = '0;
        off = '0;
        case (idx) inside
            [5'd1:5'd16]:
            begin
                off     = idx - FIRST_DATA;
                pl.hit  = 1'b1;
                pl.slot = {1'b0, off[3:2]};
                pl.pos  = off[1:0];
            end
            [5'd18:5'd21]:
            begin
                off     = idx - GAS_FIRST;
                pl.hit  = 1'b1;
                pl.slot = GAS_SLOT;
                pl.pos  = off[1:0];
            end
            default:
            begin
                pl.hit = 1'b0;
            end
        endcase
        return pl;
    endfunction

endpackage

// ===== rtl/core/sfcd_frame_parse.sv =====
// Frame tracking state: header hunt, byte index, running sum and field assembly.
`include "sensor_frame_checksum_deframer_defines.svh"

module sfcd_frame_parse (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              rx_byte,
    output sfcd_pkg::parse_status_t status,
    output sfcd_pkg::result_t       result
);

    logic        in_frame_reg, in_frame_next;
    logic [4:0]  index_reg, index_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] acc_reg  [sfcd_pkg::FIELD_COUNT];
    logic [31:0] acc_next [sfcd_pkg::FIELD_COUNT];
    logic        in_data;
    sfcd_pkg::place_t pl;

    assign in_data = (index_reg >= sfcd_pkg::FIRST_DATA) && (index_reg < sfcd_pkg::CHECK_INDEX);
    assign pl      = sfcd_pkg::byte_place(index_reg);

    assign status.in_frame = in_frame_reg;
    // Any index outside the data range closes the frame.
    assign status.is_check = in_frame_reg && !in_data;

    assign result.frame_ok          = (sum_reg == rx_byte);
    assign result.temperature_raw   = acc_reg[0];
    assign result.voltage_one_raw   = acc_reg[1];
    assign result.voltage_two_raw   = acc_reg[2];
    assign result.voltage_three_raw = acc_reg[3];
    assign result.gas_raw           = acc_reg[4];

    always_comb
    begin
        in_frame_next = in_frame_reg;
        index_next    = index_reg;
        sum_next      = sum_reg;
        for (int s = 0; s < sfcd_pkg::FIELD_COUNT; s++)
        begin
            acc_next[s] = acc_reg[s];
        end
        if (step)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == sfcd_pkg::HEADER_BYTE)
                begin
                    in_frame_next = 1'b1;
                    index_next    = sfcd_pkg::FIRST_DATA;
                    sum_next      = sfcd_pkg::HEADER_BYTE;
                    for (int s = 0; s < sfcd_pkg::FIELD_COUNT; s++)
                    begin
                        acc_next[s] = '0;
                    end
                end
            end
            else if (in_data)
            begin
                sum_next   = sum_reg + rx_byte;
                index_next = index_reg + 5'd1;
                for (int s = 0; s < sfcd_pkg::FIELD_COUNT; s++)
                begin
                    if (pl.hit && (pl.slot == 3'(s)))
                    begin
                        acc_next[s][{pl.pos, 3'b000} +: 8] = rx_byte;
                    end
                end
            end
            else
            begin
                // checksum byte: back to hunting
                in_frame_next = 1'b0;
                index_next    = '0;
                sum_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            index_reg    <= '0;
            sum_reg      <= '0;
            for (int s = 0; s < sfcd_pkg::FIELD_COUNT; s++)
            begin
                acc_reg[s] <= '0;
            end
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            index_reg    <= index_next;
            sum_reg      <= sum_next;
            for (int s = 0; s < sfcd_pkg::FIELD_COUNT; s++)
            begin
                acc_reg[s] <= acc_next[s];
            end
        end
    end

    `SFCD_ASSERT_IMPLIES(a_hunt_idle, clk, rst_n, !in_frame_reg,
        (index_reg == 5'd0) && (sum_reg == 8'd0), "hunting with stale index or sum")
    `SFCD_ASSERT_IMPLIES(a_index_range, clk, rst_n, in_frame_reg,
        (index_reg >= sfcd_pkg::FIRST_DATA) && (index_reg <= sfcd_pkg::CHECK_INDEX),
        "frame index out of range")
    `SFCD_ASSERT_NEXT(a_header_opens, clk, rst_n,
        step && !in_frame_reg && (rx_byte == sfcd_pkg::HEADER_BYTE),
        in_frame_reg && (index_reg == sfcd_pkg::FIRST_DATA)
            && (sum_reg == sfcd_pkg::HEADER_BYTE),
        "header did not open a frame")

endmodule

// ===== rtl/core/sensor_frame_checksum_deframer.sv =====
// Top level of the sensor frame deframer: input register, frame parser, result register.
// Takes one received serial byte per transfer and emits one result per 24-byte frame
// (header 0xAA, 22 data bytes, additive checksum byte). Each byte is held in the input
// register until the parser folds it into the frame state; the checksum byte loads the
// result register. A byte is taken every cycle: the input register frees as soon as its
// byte is processed, and only a checksum byte waits, and only while an earlier result is
// still held and not taken. Once the result register is free, the checksum byte passes
// from the input register into it, and the result register drives the output. Results of
// bad-checksum frames are still emitted with frame_ok low.
`include "sensor_frame_checksum_deframer_defines.svh"

module sensor_frame_checksum_deframer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // rx_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // frame_ok, temperature_raw, voltage_one_raw, voltage_two_raw,
    // voltage_three_raw, gas_raw, zero pad
    output logic [sfcd_pkg::TDATA_BITS-1:0] m_axis_tdata
);

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    out_valid_reg;
    sfcd_pkg::result_t       out_data_reg;
    logic                    out_free;
    logic                    step;
    sfcd_pkg::parse_status_t status;
    sfcd_pkg::result_t       result;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && (!status.is_check || out_free);
    assign s_axis_tready = !in_valid_reg || step;

    sfcd_frame_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .status  (status),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (step && status.is_check)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: hold until replaced
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (step && status.is_check)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(sfcd_pkg::TDATA_BITS - sfcd_pkg::RESULT_BITS){1'b0}}, out_data_reg};

    `SFCD_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, step && status.is_check, out_free,
        "result register overwritten while held")
    `SFCD_ASSERT_NEXT(a_result_source, clk, rst_n, !out_valid_reg || m_axis_tready,
        !m_axis_tvalid || $past(step && status.is_check), "result without a checksum byte")
    `SFCD_ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !s_axis_tready,
        in_valid_reg && status.is_check && out_valid_reg,
        "input stalled without a held result")

endmodule

// ===== bench/tb_sensor_frame_checksum_deframer.sv =====
// Self-checking bench for the sensor frame deframer: framed byte streams in, frame results checked.
`timescale 1ns / 100ps

module tb_sensor_frame_checksum_deframer;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int TARGET_BYTES  = 750;
    localparam int HOLD_FROM     = 400;
    localparam int HOLD_TO       = 650;
    localparam int RX_STEADY_TO  = 1000;
    localparam int BODY_LEN      = 22;

    // Tracks frame state as the block should and holds the results still owed.
    class frame_scoreboard;
        bit                 in_frame;
        bit   [4:0]         next_index;
        bit   [7:0]         sum;
        bit   [31:0]        acc [sfcd_pkg::FIELD_COUNT];
        sfcd_pkg::result_t  owed_q [$];
        int                 errors;
        int                 frames_seen;
        int                 bad_frames;

        function void note_byte(logic [7:0] b);
            sfcd_pkg::result_t r;
            int                slot;
            int                lane;
            slot = -1;
            lane = 0;
            if (!in_frame)
            begin
                if (b == sfcd_pkg::HEADER_BYTE)
                begin
                    in_frame   = 1'b1;
                    next_index = sfcd_pkg::FIRST_DATA;
                    sum        = sfcd_pkg::HEADER_BYTE;
                    foreach (acc[i]) acc[i] = '0;
                end
            end
            else if (next_index >= sfcd_pkg::FIRST_DATA && next_index < sfcd_pkg::CHECK_INDEX)
            begin
                sum = sum + b;
                if (next_index <= 5'd16)
                begin
                    slot = (next_index - sfcd_pkg::FIRST_DATA) / 4;
                    lane = (next_index - sfcd_pkg::FIRST_DATA) % 4;
                end
                else if (next_index >= sfcd_pkg::GAS_FIRST
                         && next_index <= sfcd_pkg::GAS_FIRST + 5'd3)
                begin
                    slot = sfcd_pkg::GAS_SLOT;
                    lane = next_index - sfcd_pkg::GAS_FIRST;
                end
                if (slot >= 0)
                    acc[slot] = acc[slot] | ({24'd0, b} << (8 * lane));
                next_index = next_index + 5'd1;
            end
            else
            begin
                r.frame_ok          = (sum == b);
                r.temperature_raw   = acc[0];
                r.voltage_one_raw   = acc[1];
                r.voltage_two_raw   = acc[2];
                r.voltage_three_raw = acc[3];
                r.gas_raw           = acc[4];
                owed_q.push_back(r);
                in_frame   = 1'b0;
                next_index = '0;
                sum        = '0;
            end
        endfunction

        function void check_result(logic [sfcd_pkg::TDATA_BITS-1:0] data);
            sfcd_pkg::result_t got;
            sfcd_pkg::result_t want;
            got = data[sfcd_pkg::RESULT_BITS-1:0];
            if (owed_q.size() == 0)
            begin
                $error("unexpected result transfer: %h", data);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            frames_seen++;
            if (!want.frame_ok)
                bad_frames++;
            if (got.frame_ok !== want.frame_ok)
            begin
                $error("frame_ok: expected %b, got %b", want.frame_ok, got.frame_ok);
                errors++;
            end
            if (got.temperature_raw !== want.temperature_raw)
            begin
                $error("temperature_raw: expected %h, got %h",
                       want.temperature_raw, got.temperature_raw);
                errors++;
            end
            if (got.voltage_one_raw !== want.voltage_one_raw)
            begin
                $error("voltage_one_raw: expected %h, got %h",
                       want.voltage_one_raw, got.voltage_one_raw);
                errors++;
            end
            if (got.voltage_two_raw !== want.voltage_two_raw)
            begin
                $error("voltage_two_raw: expected %h, got %h",
                       want.voltage_two_raw, got.voltage_two_raw);
                errors++;
            end
            if (got.voltage_three_raw !== want.voltage_three_raw)
            begin
                $error("voltage_three_raw: expected %h, got %h",
                       want.voltage_three_raw, got.voltage_three_raw);
                errors++;
            end
            if (got.gas_raw !== want.gas_raw)
            begin
                $error("gas_raw: expected %h, got %h", want.gas_raw, got.gas_raw);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;   // rx_byte
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // frame_ok, temperature_raw, voltage_one_raw, voltage_two_raw,
    // voltage_three_raw, gas_raw, zero pad
    logic [sfcd_pkg::TDATA_BITS-1:0] m_axis_tdata;

    frame_scoreboard sb;
    logic [7:0]      frame_body [BODY_LEN];
    bit              sender_gaps;
    int              cycle_count;
    int              rx_cycle;
    int              bytes_in_frames;
    int              noise_bytes;

    sensor_frame_checksum_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, sb.owed_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random back-pressure, one long hold-off, a steady stretch, then random again.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_cycle      <= 0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_TO)
                m_axis_tready <= 1'b0;
            else if (rx_cycle >= HOLD_TO && rx_cycle < RX_STEADY_TO)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_byte(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    task automatic send_byte(input logic [7:0] b);
        if (sender_gaps)
        begin
            while ($urandom_range(99) < 30)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Send header, body and checksum; flip checksum bits when asked to corrupt.
    task automatic send_frame(input bit corrupt);
        logic [7:0] check;
        logic [7:0] flip;
        check = sfcd_pkg::HEADER_BYTE;
        foreach (frame_body[i]) check = check + frame_body[i];
        flip = 8'($urandom_range(1, 255));
        if (corrupt)
            check = check ^ flip;
        send_byte(sfcd_pkg::HEADER_BYTE);
        foreach (frame_body[i]) send_byte(frame_body[i]);
        send_byte(check);
        bytes_in_frames += BODY_LEN + 2;
    endtask

    function automatic logic [7:0] pick_body_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 8'h00;
        if (roll < 20)
            return 8'hFF;
        if (roll < 25)
            return sfcd_pkg::HEADER_BYTE;
        return 8'($urandom_range(255));
    endfunction

    initial
    begin
        int frame_no;
        int n_noise;
        int n_trunc;
        int kind;
        logic [7:0] nb;

        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cycle_count   = 0;
        sender_gaps   = 1'b1;
        bytes_in_frames = 0;
        noise_bytes   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Line noise while hunting must be dropped.
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'hFF);
        noise_bytes += 3;

        // All ones, header value inside the frame and in the skipped bytes, bad checksum.
        foreach (frame_body[i]) frame_body[i] = 8'hFF;
        frame_body[2]  = sfcd_pkg::HEADER_BYTE;
        frame_body[16] = sfcd_pkg::HEADER_BYTE;
        frame_body[21] = sfcd_pkg::HEADER_BYTE;
        send_frame(1'b1);

        // All zeros right after: fields must not keep the previous frame's ones.
        foreach (frame_body[i]) frame_body[i] = 8'h00;
        send_frame(1'b0);

        frame_no = 0;
        while (bytes_in_frames + noise_bytes < TARGET_BYTES)
        begin
            sender_gaps = !(frame_no >= 10 && frame_no < 16);
            n_noise = $urandom_range(0, 3);
            repeat (n_noise)
            begin
                nb = 8'($urandom_range(255));
                // Mostly non-header noise; a stray header now and then breaks the framing.
                if (nb == sfcd_pkg::HEADER_BYTE && $urandom_range(99) < 70)
                    nb = 8'h00;
                send_byte(nb);
                noise_bytes++;
            end
            kind = $urandom_range(99);
            if (kind < 12)
            begin
                // Truncated frame: header and a few bytes, then the next frame follows.
                n_trunc = $urandom_range(1, 12);
                send_byte(sfcd_pkg::HEADER_BYTE);
                repeat (n_trunc) send_byte(pick_body_byte());
                bytes_in_frames += n_trunc + 1;
            end
            else
            begin
                foreach (frame_body[i]) frame_body[i] = pick_body_byte();
                send_frame($urandom_range(99) < 25);
            end
            frame_no++;
        end

        s_axis_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d frame results (%0d with bad checksum), %0d noise bytes,",
                 sb.frames_seen, sb.bad_frames, noise_bytes);
        $display("random stalls on both sides and one long output hold-off");
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
